// ===== sv/mfpa_pkg.sv =====
// Shared constants, payload types and back-end state type for the frame averager.
`timescale 1ns / 1ps
`default_nettype none

package mfpa_pkg;

   // Default limits, handed down as top-level parameters
   localparam int MAX_PIXELS  = 65536;
   localparam int MAX_IMAGES  = 256;
   localparam int QUEUE_DEPTH = 4;

   // Fixed field widths
   localparam int AVG_W   = 8;
   localparam int INDEX_W = 16;
   localparam int CFG_W   = 17;
   localparam int STEP_W  = $clog2(AVG_W);

   // Register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] FRAME_PIXELS_ADDR = '0;
   localparam logic [CFG_W-1:0] FRAME_PIXELS_RESET = 17'h10000;

   // One incoming pixel
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       final_image;
   } pixel_in_type;

   // One averaged pixel
   typedef struct packed {
      logic [AVG_W-1:0]   avg_red;
      logic [AVG_W-1:0]   avg_green;
      logic [AVG_W-1:0]   avg_blue;
      logic [INDEX_W-1:0] pixel_index;
      logic               last;
      logic               forced_last;
   } pixel_out_type;

   // Back-end sequencer
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SUM,
      BK_DIV,
      BK_HOLD
   } back_state_type;

endpackage

`default_nettype wire

// ===== sv/multi_frame_pixel_average_core.sv =====
// Top level of the multi-frame RGB pixel averager: register port, front end, queue, back end.
//
//   Port group   Direction  Payload / purpose
//   req_*        in         pixel_in_type: red, green, blue, final_image
//   rsp_*        out        pixel_out_type: averages, pixel_index, last, forced_last
//   p* (APB)     in/out     frame_pixels register at byte address 0
//
// The front end takes one pixel per cycle while the command queue has room.
// The back end handles a summed pixel as a sum RAM read, then add and write
// back, and an averaged pixel as read, add, 8 serial divide steps, result
// load; the sum read-modify-write and the divider set the rate.
// Reset is synchronous; the sum RAM is not cleared and needs no clearing pass.
// A stalled result holds in the output register while the front end keeps
// filling the queue.
`timescale 1ns / 1ps
`default_nettype none

module multi_frame_pixel_average_core #(
   parameter int MAX_PIXELS  = mfpa_pkg::MAX_PIXELS,
   parameter int MAX_IMAGES  = mfpa_pkg::MAX_IMAGES,
   parameter int QUEUE_DEPTH = mfpa_pkg::QUEUE_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire mfpa_pkg::pixel_in_type             req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output mfpa_pkg::pixel_out_type                rsp_data,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [mfpa_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [mfpa_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [mfpa_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                   pready
);

   localparam int CFG_W = mfpa_pkg::CFG_W;
   localparam int PIX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CNT_W = $clog2(MAX_IMAGES + 1);
   localparam int SUM_W = mfpa_pkg::AVG_W + $clog2(MAX_IMAGES);
   localparam int NP_W  = (PIX_W + 1 > CFG_W) ? PIX_W + 1 : CFG_W;
   localparam int RESET_PIXELS =
      (int'(mfpa_pkg::FRAME_PIXELS_RESET) > MAX_PIXELS) ? MAX_PIXELS
                                                        : int'(mfpa_pkg::FRAME_PIXELS_RESET);
   localparam logic [PIX_W-1:0] LAST_IDX_RESET = PIX_W'(RESET_PIXELS - 1);

   typedef struct packed {
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [PIX_W-1:0] idx;
      logic [CNT_W-1:0] count;
      logic             accumulate;
      logic             closing;
      logic             forced;
      logic             last;
   } mfpa_cmd_type;

   logic [CFG_W-1:0] frame_pixels_ff, frame_pixels_in;
   logic [PIX_W-1:0] last_idx_ff, last_idx_in;
   logic [NP_W-1:0]  wr_pixels;
   logic [NP_W-1:0]  eff_pixels;
   logic             csr_write;

   mfpa_cmd_type     push_data;
   logic             push_valid, push_ready;
   mfpa_cmd_type     pop_data;
   logic             pop_valid, pop_ready;

   // Register port; writes land at every address, reads answer only at the register's own
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign prdata    = (paddr == mfpa_pkg::FRAME_PIXELS_ADDR)
                      ? mfpa_pkg::CSR_DATA_W'(frame_pixels_ff) : '0;

   // Clamp the written frame size and keep its last raster index
   always_comb begin
      frame_pixels_in = pwdata[CFG_W-1:0];
      wr_pixels       = NP_W'(frame_pixels_in);
      eff_pixels      = wr_pixels;
      if (wr_pixels == '0) begin
         eff_pixels = NP_W'(1);
      end else if (wr_pixels > NP_W'(MAX_PIXELS)) begin
         eff_pixels = NP_W'(MAX_PIXELS);
      end
      last_idx_in = PIX_W'(eff_pixels - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pixels_ff <= mfpa_pkg::FRAME_PIXELS_RESET;
         last_idx_ff     <= LAST_IDX_RESET;
      end else if (csr_write) begin
         frame_pixels_ff <= frame_pixels_in;
         last_idx_ff     <= last_idx_in;
      end
   end

   mfpa_front #(
      .PIX_W      (PIX_W),
      .CNT_W      (CNT_W),
      .MAX_IMAGES (MAX_IMAGES),
      .cmd_type   (mfpa_cmd_type)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .last_idx   (last_idx_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   mfpa_queue #(
      .DEPTH     (QUEUE_DEPTH),
      .item_type (mfpa_cmd_type)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   mfpa_back #(
      .PIX_W      (PIX_W),
      .SUM_W      (SUM_W),
      .MAX_PIXELS (MAX_PIXELS),
      .cmd_type   (mfpa_cmd_type)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sv/mfpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mfpa_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65536,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [ADDR_W-1:0]      wr_addr,
   input  wire logic [WIDTH-1:0]       wr_data,
   input  wire logic                   rd_en,
   input  wire logic [ADDR_W-1:0]      rd_addr,
   output logic      [WIDTH-1:0]       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/mfpa_queue.sv =====
// Short command queue between the classifying front end and the accumulating back end.
`timescale 1ns / 1ps
`default_nettype none

module mfpa_queue #(
   parameter int  DEPTH     = mfpa_pkg::QUEUE_DEPTH,
   parameter type item_type = logic
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   output logic          push_ready,
   input  wire item_type push_data,
   output logic          pop_valid,
   input  wire logic     pop_ready,
   output item_type      pop_data
);

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   item_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              push, pop;

   assign push_ready = (fill_ff != FILL_W'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store pushed commands
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== sv/mfpa_front.sv =====
// Front end: tracks raster position and image count, classifies each pixel into a command.
`timescale 1ns / 1ps
`default_nettype none

module mfpa_front #(
   parameter int  PIX_W      = 16,
   parameter int  CNT_W      = 9,
   parameter int  MAX_IMAGES = mfpa_pkg::MAX_IMAGES,
   parameter type cmd_type   = logic
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire mfpa_pkg::pixel_in_type req_data,
   input  wire logic [PIX_W-1:0]      last_idx,
   output logic                       push_valid,
   input  wire logic                  push_ready,
   output cmd_type                    push_data
);

   logic [PIX_W-1:0] position_ff, position_in;
   logic [CNT_W-1:0] images_seen_ff, images_seen_in;
   logic             closing_ff, closing_in;
   logic             forced_ff, forced_in;

   logic [PIX_W-1:0] idx;
   logic [CNT_W-1:0] count;
   logic             first_pixel;
   logic             end_of_image;
   logic             forced_now;
   logic             accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid & push_ready;

   // Clamp position to the frame, and classify the pixel
   always_comb begin
      idx          = (position_ff > last_idx) ? last_idx : position_ff;
      end_of_image = (idx == last_idx);
      first_pixel  = (idx == '0);
      count        = images_seen_ff + 1'b1;
      forced_now   = (count >= CNT_W'(MAX_IMAGES));
      closing_in   = first_pixel ? (req_data.final_image | forced_now) : closing_ff;
      forced_in    = first_pixel ? forced_now : forced_ff;
   end

   // Next position and image count
   always_comb begin
      position_in    = idx + 1'b1;
      images_seen_in = images_seen_ff;
      if (end_of_image) begin
         position_in    = '0;
         images_seen_in = closing_in ? '0 : count;
      end
   end

   // Build the command for the back end
   always_comb begin
      push_data            = '0;
      push_data.red        = req_data.red;
      push_data.green      = req_data.green;
      push_data.blue       = req_data.blue;
      push_data.idx        = idx;
      push_data.count      = count;
      push_data.accumulate = (images_seen_ff != '0);
      push_data.closing    = closing_in;
      push_data.forced     = forced_in;
      push_data.last       = end_of_image;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         images_seen_ff <= '0;
         closing_ff     <= 1'b0;
         forced_ff      <= 1'b0;
      end else if (accept) begin
         position_ff    <= position_in;
         images_seen_ff <= images_seen_in;
         closing_ff     <= closing_in;
         forced_ff      <= forced_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/mfpa_back.sv =====
// Back end: read-modify-write of the per-pixel sums and serial division for averaged output.
`timescale 1ns / 1ps
`default_nettype none

module mfpa_back #(
   parameter int  PIX_W      = 16,
   parameter int  SUM_W      = 16,
   parameter int  MAX_PIXELS = mfpa_pkg::MAX_PIXELS,
   parameter type cmd_type   = logic
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    pop_valid,
   output logic                         pop_ready,
   input  wire cmd_type                 pop_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output mfpa_pkg::pixel_out_type      rsp_data
);

   localparam int AVG_W  = mfpa_pkg::AVG_W;
   localparam int STEP_W = mfpa_pkg::STEP_W;

   mfpa_pkg::back_state_type state_ff, state_in;

   cmd_type                       cmd_ff;
   logic [2:0][SUM_W-1:0]         rem_ff, rem_in;
   logic [SUM_W-1:0]              div_ff;
   logic [2:0][AVG_W-1:0]         quo_ff, quo_in;
   logic [STEP_W-1:0]             step_ff;
   mfpa_pkg::pixel_out_type       res_ff;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic [2:0][7:0]               pixel;
   logic [2:0][SUM_W-1:0]         sum_now;
   logic [3*SUM_W-1:0]            ram_rd_data;
   logic                          ram_rd_en;
   logic                          ram_wr_en;
   logic                          div_load;
   logic                          div_step;
   logic                          res_load;
   logic                          out_free;
   logic                          last_step;

   // Per-pixel channel sums
   mfpa_ram #(
      .WIDTH (3 * SUM_W),
      .DEPTH (MAX_PIXELS)
   ) u_sums (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cmd_ff.idx),
      .wr_data (sum_now),
      .rd_en   (ram_rd_en),
      .rd_addr (pop_data.idx),
      .rd_data (ram_rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_step = (step_ff == STEP_W'(AVG_W - 1));

   // Add the stored sums unless this is the first image of the set
   always_comb begin
      pixel = {cmd_ff.red, cmd_ff.green, cmd_ff.blue};
      for (int c = 0; c < 3; c++) begin
         sum_now[c] = SUM_W'(pixel[c]);
         if (cmd_ff.accumulate) begin
            sum_now[c] = SUM_W'(pixel[c]) + ram_rd_data[c*SUM_W +: SUM_W];
         end
      end
   end

   // One restoring-division step per channel
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (rem_ff[c] >= div_ff) begin
            rem_in[c] = rem_ff[c] - div_ff;
            quo_in[c] = {quo_ff[c][AVG_W-2:0], 1'b1};
         end else begin
            rem_in[c] = rem_ff[c];
            quo_in[c] = {quo_ff[c][AVG_W-2:0], 1'b0};
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfpa_pkg::BK_IDLE: begin
            if (pop_valid) state_in = mfpa_pkg::BK_SUM;
         end
         mfpa_pkg::BK_SUM: begin
            state_in = cmd_ff.closing ? mfpa_pkg::BK_DIV : mfpa_pkg::BK_IDLE;
         end
         mfpa_pkg::BK_DIV: begin
            if (last_step) state_in = mfpa_pkg::BK_HOLD;
         end
         mfpa_pkg::BK_HOLD: begin
            if (out_free) state_in = mfpa_pkg::BK_IDLE;
         end
         default: state_in = mfpa_pkg::BK_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      pop_ready = 1'b0;
      ram_rd_en = 1'b0;
      ram_wr_en = 1'b0;
      div_load  = 1'b0;
      div_step  = 1'b0;
      res_load  = 1'b0;
      unique case (state_ff)
         mfpa_pkg::BK_IDLE: begin
            pop_ready = 1'b1;
            ram_rd_en = pop_valid;
         end
         mfpa_pkg::BK_SUM: begin
            ram_wr_en = !cmd_ff.closing;
            div_load  = cmd_ff.closing;
         end
         mfpa_pkg::BK_DIV: begin
            div_step = 1'b1;
         end
         mfpa_pkg::BK_HOLD: begin
            res_load = out_free;
         end
         default: ;
      endcase
   end

   // Result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfpa_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Command, divider and result datapath
   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         cmd_ff <= pop_data;
      end
      if (div_load) begin
         rem_ff  <= sum_now;
         div_ff  <= SUM_W'(cmd_ff.count) << (AVG_W - 1);
         quo_ff  <= '0;
         step_ff <= '0;
      end else if (div_step) begin
         rem_ff  <= rem_in;
         div_ff  <= div_ff >> 1;
         quo_ff  <= quo_in;
         step_ff <= step_ff + 1'b1;
      end
      if (res_load) begin
         res_ff.avg_red     <= quo_ff[2];
         res_ff.avg_green   <= quo_ff[1];
         res_ff.avg_blue    <= quo_ff[0];
         res_ff.pixel_index <= mfpa_pkg::INDEX_W'(cmd_ff.idx);
         res_ff.last        <= cmd_ff.last;
         res_ff.forced_last <= cmd_ff.forced;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = res_ff;

endmodule

`default_nettype wire

// ===== verif/multi_frame_pixel_average_core_test.sv =====
// Self-checking testbench for the multi-frame pixel averager: a running model of the sums.
`timescale 1ns / 1ps

module multi_frame_pixel_average_core_test;
   import mfpa_pkg::*;

   localparam int DRAIN_CYCLES   = 100;
   localparam int LONG_STALL     = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RUN_PIXELS     = 1230;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   pixel_in_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   pixel_out_type         rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Pixels waiting for the sender, averages waiting for the block
   pixel_in_type  pixel_queue[$];
   pixel_out_type expected_averages[$];

   // Running copy of the averager state
   logic [CFG_W-1:0] frame_size_reg = FRAME_PIXELS_RESET;
   bit [15:0] sum_red   [MAX_PIXELS];
   bit [15:0] sum_green [MAX_PIXELS];
   bit [15:0] sum_blue  [MAX_PIXELS];
   int  raster_pos    = 0;
   int  images_summed = 0;
   bit  closing_set   = 1'b0;
   bit  limit_hit     = 1'b0;

   int pixels_queued   = 0;
   int pixels_accepted = 0;
   int results_seen    = 0;
   int forced_seen     = 0;
   int size_writes     = 0;
   int mismatches      = 0;

   // Sender pacing
   int burst_left = 0;
   int gap_left   = 0;
   // Receiver pacing
   int stall_left    = 0;
   int next_stall_at = 10;
   int rx_mode       = 0;
   int rx_mode_left  = 0;
   int quiet_cycles  = 0;

   multi_frame_pixel_average_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Add one accepted pixel into the sums; emit its average on the closing image
   function automatic void accumulate_pixel(input pixel_in_type px);
      int npix, count, idx, r, g, b;
      bit end_img;
      pixel_out_type avg;
      npix = frame_size_reg;
      if (npix == 0) npix = 1;
      if (npix > MAX_PIXELS) npix = MAX_PIXELS;
      count = images_summed + 1;
      // a frame that shrank under the current position ends on this pixel
      if (raster_pos >= npix) raster_pos = npix - 1;
      idx = raster_pos;
      if (idx == 0) begin
         limit_hit   = (count >= MAX_IMAGES);
         closing_set = px.final_image || limit_hit;
      end
      r = px.red;
      g = px.green;
      b = px.blue;
      if (images_summed != 0) begin
         r += sum_red[idx];
         g += sum_green[idx];
         b += sum_blue[idx];
      end
      end_img = (idx + 1 >= npix);
      if (closing_set) begin
         avg.avg_red     = 8'(r / count);
         avg.avg_green   = 8'(g / count);
         avg.avg_blue    = 8'(b / count);
         avg.pixel_index = 16'(idx);
         avg.last        = end_img;
         avg.forced_last = limit_hit;
         expected_averages.insert(expected_averages.size(), avg);
      end else begin
         sum_red[idx]   = 16'(r);
         sum_green[idx] = 16'(g);
         sum_blue[idx]  = 16'(b);
      end
      if (end_img) begin
         raster_pos    = 0;
         images_summed = closing_set ? 0 : count;
      end else begin
         raster_pos = idx + 1;
      end
   endfunction

   function automatic void compare_field(input string label, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
         mismatches++;
      end
   endfunction

   function automatic logic [7:0] random_channel();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void push_pixel(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b, input logic fin);
      pixel_in_type px;
      px.red         = r;
      px.green       = g;
      px.blue        = b;
      px.final_image = fin;
      pixel_queue.insert(pixel_queue.size(), px);
      pixels_queued++;
   endfunction

   // One image of random pixels; the flag only matters on its first pixel
   function automatic void queue_image(input int npix, input logic fin);
      for (int p = 0; p < npix; p++)
         push_pixel(random_channel(), random_channel(), random_channel(),
                    (p == 0) ? fin : logic'($urandom_range(0, 1)));
   endfunction

   function automatic int pick_frame_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 0;
      if (r < 60) return $urandom_range(1, 4);
      if (r < 90) return $urandom_range(5, 16);
      return $urandom_range(17, 64);
   endfunction

   function automatic int pick_image_count(input int npix);
      int r;
      r = $urandom_range(0, 9);
      if (npix > 16) return $urandom_range(1, 2);
      if (r < 3) return 1;
      if (r < 6) return 2;
      if (r < 8) return 3;
      return $urandom_range(4, 8);
   endfunction

   // Wait for every pixel to go in and every average to come out, then let the block settle
   task automatic wait_until_idle();
      while (pixels_accepted != pixels_queued || expected_averages.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_size(input int value);
      wait_until_idle();
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= FRAME_PIXELS_ADDR;
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      frame_size_reg = CFG_W'(value);
      size_writes++;
   endtask

   // Sender: bursts of random length with random gaps
   always @(posedge clock) begin : drive_pixels
      pixel_in_type next_px;
      logic next_valid;
      next_px    = req_data;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            accumulate_pixel(req_data);
            pixels_accepted++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pixel_queue.size() > 0) begin
               next_px    = pixel_queue.pop_front();
               next_valid = 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
      req_valid <= next_valid;
      req_data  <= next_px;
   end

   // Receiver: check each transfer, then pick the next ready level
   always @(posedge clock) begin : collect_averages
      pixel_out_type want;
      logic next_ready;
      next_ready = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_data.forced_last) forced_seen++;
            if (expected_averages.size() == 0) begin
               $display("%0t: unexpected average at index %0d", $time, rsp_data.pixel_index);
               mismatches++;
            end else begin
               want = expected_averages.pop_front();
               compare_field("avg_red", want.avg_red, rsp_data.avg_red);
               compare_field("avg_green", want.avg_green, rsp_data.avg_green);
               compare_field("avg_blue", want.avg_blue, rsp_data.avg_blue);
               compare_field("pixel_index", want.pixel_index, rsp_data.pixel_index);
               compare_field("last", want.last, rsp_data.last);
               compare_field("forced_last", want.forced_last, rsp_data.forced_last);
            end
         end
         if (stall_left > 0) begin
            // hold off so the queue fills and the input backs up
            stall_left--;
         end else if (results_seen >= next_stall_at && rsp_valid &&
                      pixel_queue.size() > 200) begin
            stall_left    = LONG_STALL;
            next_stall_at = results_seen + 600;
         end else begin
            if (rx_mode_left == 0) begin
               rx_mode      = $urandom_range(0, 2);
               rx_mode_left = $urandom_range(16, 200);
            end
            rx_mode_left--;
            case (rx_mode)
               0: next_ready = 1'b1;
               1: next_ready = logic'($urandom_range(0, 1));
               default: next_ready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
      rsp_ready <= next_ready;
   end

   // Watchdog: give up after a long stretch with no transfer anywhere
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d averages outstanding",
                  $time, quiet_cycles, expected_averages.size());
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int cur_size, npix, k, j, m, s, eff, rem;
      bit limit_done, wide_done;
      limit_done = 1'b0;
      wide_done  = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Single-image sets: each average is the pixel itself, channel extremes
      write_frame_size(1);
      push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      push_pixel(8'hAA, 8'h55, 8'h0F, 1'b1);
      // Two full-scale images must average back to full scale
      push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
      // Zero frame size behaves as one pixel
      write_frame_size(0);
      push_pixel(8'd13, 8'd200, 8'd7, 1'b0);
      push_pixel(8'd100, 8'd0, 8'd255, 1'b1);
      // Three images of two pixels; last-image flag set inside images is ignored
      write_frame_size(2);
      push_pixel(8'd10, 8'd20, 8'd30, 1'b0);
      push_pixel(8'd40, 8'd50, 8'd60, 1'b1);
      push_pixel(8'd7, 8'd8, 8'd9, 1'b0);
      push_pixel(8'd1, 8'd2, 8'd3, 1'b1);
      push_pixel(8'd200, 8'd100, 8'd50, 1'b1);
      push_pixel(8'd255, 8'd254, 8'd253, 1'b0);
      // Largest frame, then shrink mid-image so the next pixel closes the frame
      write_frame_size(MAX_PIXELS);
      queue_image(3, 1'b1);
      write_frame_size(4);
      push_pixel(random_channel(), random_channel(), random_channel(), 1'b0);
      // Oversized value clamps; shrink below the position while summing
      write_frame_size((1 << CFG_W) - 1);
      queue_image(4, 1'b0);
      write_frame_size(2);
      push_pixel(random_channel(), random_channel(), random_channel(), 1'b1);
      queue_image(2, 1'b1);
      cur_size = 2;

      // Random sets of mostly small frames
      while (pixels_queued < RUN_PIXELS) begin
         if (!limit_done && pixels_queued > 500) begin
            // never flag the last image: the image limit has to close the set
            write_frame_size(1);
            cur_size = 1;
            for (int i = 0; i < MAX_IMAGES; i++) queue_image(1, 1'b0);
            limit_done = 1'b1;
         end else if (!wide_done && pixels_queued > 900) begin
            cur_size = $urandom_range(257, 260);
            write_frame_size(cur_size);
            queue_image(cur_size, 1'b1);
            wide_done = 1'b1;
         end else begin
            if ($urandom_range(0, 2) == 0) begin
               cur_size = pick_frame_size();
               write_frame_size(cur_size);
            end
            npix = (cur_size == 0) ? 1 : cur_size;
            k = pick_image_count(npix);
            if (k > 1 && npix > 1 && $urandom_range(0, 3) == 0) begin
               // shrink the frame part way through the set
               j = $urandom_range(1, k - 1);
               for (int i = 0; i < j; i++) queue_image(npix, 1'b0);
               m = $urandom_range(0, npix - 1);
               for (int p = 0; p < m; p++)
                  push_pixel(random_channel(), random_channel(), random_channel(),
                             (p == 0) ? (j == k - 1) : logic'($urandom_range(0, 1)));
               s = $urandom_range(0, npix - 1);
               write_frame_size(s);
               cur_size = s;
               eff = (s == 0) ? 1 : s;
               if (m > 0) begin
                  rem = eff - ((m < eff) ? m : eff - 1);
                  // a one-pixel frame lands on its first pixel, so keep the set's intent
                  for (int p = 0; p < rem; p++)
                     push_pixel(random_channel(), random_channel(), random_channel(),
                                (eff == 1) ? logic'(j == k - 1)
                                           : logic'($urandom_range(0, 1)));
                  j++;
               end
               for (int i = j; i < k; i++) queue_image(eff, i == k - 1);
            end else begin
               for (int i = 0; i < k; i++) queue_image(npix, i == k - 1);
            end
         end
      end

      wait_until_idle();
      $display("Fed %0d pixels over %0d frame-size settings; checked %0d averages,",
               pixels_accepted, size_writes, results_seen);
      $display("%0d of them closed by the image limit, %0d field mismatches.",
               forced_seen, mismatches);
      if (mismatches == 0 && expected_averages.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
